[rtl/core/segment_intersection_3d_defines.svh]
// ----------------------------------------------------------------------------
// Segment intersection assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_3D_DEFINES_SVH
`define SEGMENT_INTERSECTION_3D_DEFINES_SVH

// Property that holds at every clock edge
`define SGI3D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication
`define SGI3D_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SGI3D_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/sgi3d_pkg.sv]
// ----------------------------------------------------------------------------
// Segment intersection package
// Control and status types shared by the top level and the dot product unit.
// ----------------------------------------------------------------------------
package sgi3d_pkg;

  typedef struct packed {
    logic ld_part;
    logic ld_term;
    logic ld_sum;
  } sgi3d_dot_en_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } sgi3d_sign_t;

endpackage

[rtl/core/sgi3d_dot_sign.sv]
// ----------------------------------------------------------------------------
// Segment intersection dot product sign unit
// Three-stage exact dot product of two 3-vectors: split partial products,
// per-lane recombination, lane sum. Reports sign and zero of the sum.
// ----------------------------------------------------------------------------
module sgi3d_dot_sign
  import sgi3d_pkg::*;
#(
  parameter int unsigned ELEM_BITS = 35
) (
  input  logic                         clk_i,
  input  sgi3d_dot_en_t                en_i,
  input  logic [2:0][ELEM_BITS-1:0]    u_i,
  input  logic [2:0][ELEM_BITS-1:0]    v_i,
  output sgi3d_sign_t                  sign_o
);

  localparam int unsigned LoBits   = (ELEM_BITS + 1) / 2;
  localparam int unsigned HiBits   = ELEM_BITS - LoBits;
  localparam int unsigned HhBits   = 2 * HiBits;
  localparam int unsigned LlBits   = 2 * LoBits;
  localparam int unsigned CrBits   = HiBits + LoBits + 1;
  localparam int unsigned MidBits  = CrBits + 1;
  localparam int unsigned TermBits = 2 * ELEM_BITS;
  localparam int unsigned SumBits  = TermBits + 2;

  logic [2:0][HhBits-1:0]   hh_d, hh_q;
  logic [2:0][CrBits-1:0]   hl_d, hl_q;
  logic [2:0][CrBits-1:0]   lh_d, lh_q;
  logic [2:0][LlBits-1:0]   ll_d, ll_q;
  logic [2:0][MidBits-1:0]  mid;
  logic [2:0][TermBits-1:0] term_d, term_q;
  logic [SumBits-1:0]       sum_d, sum_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hh_d[i] = HhBits'($signed(u_i[i][ELEM_BITS-1:LoBits]))
              * HhBits'($signed(v_i[i][ELEM_BITS-1:LoBits]));
      hl_d[i] = CrBits'($signed(u_i[i][ELEM_BITS-1:LoBits]))
              * CrBits'($signed({1'b0, v_i[i][LoBits-1:0]}));
      lh_d[i] = CrBits'($signed({1'b0, u_i[i][LoBits-1:0]}))
              * CrBits'($signed(v_i[i][ELEM_BITS-1:LoBits]));
      ll_d[i] = LlBits'(u_i[i][LoBits-1:0]) * LlBits'(v_i[i][LoBits-1:0]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mid[i]    = MidBits'($signed(hl_q[i])) + MidBits'($signed(lh_q[i]));
      term_d[i] = {hh_q[i], ll_q[i]} + (TermBits'($signed(mid[i])) << LoBits);
    end
  end

  assign sum_d = SumBits'($signed(term_q[0])) + SumBits'($signed(term_q[1]))
               + SumBits'($signed(term_q[2]));

  always_ff @(posedge clk_i) begin
    if (en_i.ld_part) begin
      hh_q <= hh_d;
      hl_q <= hl_d;
      lh_q <= lh_d;
      ll_q <= ll_d;
    end
    if (en_i.ld_term) begin
      term_q <= term_d;
    end
    if (en_i.ld_sum) begin
      sum_q <= sum_d;
    end
  end

  assign sign_o.neg  = sum_q[SumBits-1];
  assign sign_o.zero = (sum_q == '0);

endmodule

[rtl/core/segment_intersection_3d.sv]
// ----------------------------------------------------------------------------
// Segment intersection 3D
// Exact test of two 3D segments AB and CD for a crossing, a touching
// endpoint, or collinear containment of CD strictly inside AB.
// ----------------------------------------------------------------------------
//  Channel   Handshake                  Payload
//  in        in_valid_i / in_ready_o    a_*_i b_*_i c_*_i d_*_i (x, y, z)
//  out       out_valid_o / out_ready_i  hit_o
//
//  One transaction per cycle sustained while out_ready_i is high; out_valid_o
//  rises once an accepted transaction reaches the last of six register
//  stages. Stages: differences and endpoint order, cross products, split
//  partial products, lane recombination, dot sums, result.
//  Reset clears only the stage valid bits; no sweep after reset.
//  A stalled output holds its stage; earlier stages keep filling bubbles,
//  so in_ready_o drops only when all six stages hold a transaction.
// ----------------------------------------------------------------------------
`include "segment_intersection_3d_defines.svh"

module segment_intersection_3d
  import sgi3d_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] a_x_i,
  input  logic signed [COORD_BITS-1:0] a_y_i,
  input  logic signed [COORD_BITS-1:0] a_z_i,
  input  logic signed [COORD_BITS-1:0] b_x_i,
  input  logic signed [COORD_BITS-1:0] b_y_i,
  input  logic signed [COORD_BITS-1:0] b_z_i,
  input  logic signed [COORD_BITS-1:0] c_x_i,
  input  logic signed [COORD_BITS-1:0] c_y_i,
  input  logic signed [COORD_BITS-1:0] c_z_i,
  input  logic signed [COORD_BITS-1:0] d_x_i,
  input  logic signed [COORD_BITS-1:0] d_y_i,
  input  logic signed [COORD_BITS-1:0] d_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         hit_o
);

  localparam int unsigned DiffBits  = COORD_BITS + 1;
  localparam int unsigned ProdBits  = 2 * DiffBits;
  localparam int unsigned CrossBits = 2 * COORD_BITS + 3;
  localparam int unsigned NumStages = 6;
  localparam int unsigned StDiff    = 0;
  localparam int unsigned StCross   = 1;
  localparam int unsigned StPart    = 2;
  localparam int unsigned StTerm    = 3;
  localparam int unsigned StSum     = 4;
  localparam int unsigned StOut     = 5;

  typedef logic [2:0][COORD_BITS-1:0] pt_t;
  typedef logic [2:0][DiffBits-1:0]   dvec_t;
  typedef logic [2:0][CrossBits-1:0]  cvec_t;

  function automatic logic lex_lt(input pt_t p, input pt_t q);
    logic lt_x, lt_y, lt_z;
    lt_x = $signed(p[0]) < $signed(q[0]);
    lt_y = $signed(p[1]) < $signed(q[1]);
    lt_z = $signed(p[2]) < $signed(q[2]);
    return lt_x || ((p[0] == q[0]) && (lt_y || ((p[1] == q[1]) && lt_z)));
  endfunction

  function automatic dvec_t sub3(input pt_t p, input pt_t q);
    dvec_t w;
    for (int i = 0; i < 3; i++) begin
      w[i] = DiffBits'($signed(p[i])) - DiffBits'($signed(q[i]));
    end
    return w;
  endfunction

  function automatic cvec_t cross3(input dvec_t u, input dvec_t v);
    logic signed [ProdBits-1:0] p0, p1, p2, p3, p4, p5;
    cvec_t w;
    p0 = ProdBits'($signed(u[1])) * ProdBits'($signed(v[2]));
    p1 = ProdBits'($signed(u[2])) * ProdBits'($signed(v[1]));
    p2 = ProdBits'($signed(u[2])) * ProdBits'($signed(v[0]));
    p3 = ProdBits'($signed(u[0])) * ProdBits'($signed(v[2]));
    p4 = ProdBits'($signed(u[0])) * ProdBits'($signed(v[1]));
    p5 = ProdBits'($signed(u[1])) * ProdBits'($signed(v[0]));
    w[0] = CrossBits'(p0) - CrossBits'(p1);
    w[1] = CrossBits'(p2) - CrossBits'(p3);
    w[2] = CrossBits'(p4) - CrossBits'(p5);
    return w;
  endfunction

  logic [NumStages-1:0] valid_d, valid_q;
  logic [NumStages-1:0] ld;

  pt_t   pt_a, pt_b, pt_c, pt_d;
  pt_t   s1, e1, s2, e2;
  logic  ab_lt, cd_lt, order_d;

  dvec_t ab_q, ac_q, ad_q, cd_q, ca_q, cb_q;
  logic  order1_q, order2_q;
  cvec_t acab_q, adab_q, cacd_q, cbcd_q, abcd_q, abac_q;
  logic  coll3_q, coll4_q, coll5_q;
  logic  hit_d, hit_q;

  sgi3d_dot_en_t dot_en;
  sgi3d_sign_t   side_cd, side_ab;

  always_comb begin
    ld[StOut] = !valid_q[StOut] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      ld[k] = !valid_q[k] || ld[k+1];
    end
  end

  always_comb begin
    valid_d[StDiff] = ld[StDiff] ? in_valid_i : valid_q[StDiff];
    for (int k = 1; k < NumStages; k++) begin
      valid_d[k] = ld[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign pt_a = {a_z_i, a_y_i, a_x_i};
  assign pt_b = {b_z_i, b_y_i, b_x_i};
  assign pt_c = {c_z_i, c_y_i, c_x_i};
  assign pt_d = {d_z_i, d_y_i, d_x_i};

  // Order each segment's endpoints; collinear hit needs CD strictly inside AB
  assign ab_lt   = lex_lt(pt_a, pt_b);
  assign cd_lt   = lex_lt(pt_c, pt_d);
  assign s1      = ab_lt ? pt_a : pt_b;
  assign e1      = ab_lt ? pt_b : pt_a;
  assign s2      = cd_lt ? pt_c : pt_d;
  assign e2      = cd_lt ? pt_d : pt_c;
  assign order_d = lex_lt(s1, s2) && lex_lt(e2, e1);

  always_ff @(posedge clk_i) begin
    if (ld[StDiff]) begin
      ab_q     <= sub3(pt_b, pt_a);
      ac_q     <= sub3(pt_c, pt_a);
      ad_q     <= sub3(pt_d, pt_a);
      cd_q     <= sub3(pt_d, pt_c);
      ca_q     <= sub3(pt_a, pt_c);
      cb_q     <= sub3(pt_b, pt_c);
      order1_q <= order_d;
    end
    if (ld[StCross]) begin
      acab_q   <= cross3(ac_q, ab_q);
      adab_q   <= cross3(ad_q, ab_q);
      cacd_q   <= cross3(ca_q, cd_q);
      cbcd_q   <= cross3(cb_q, cd_q);
      abcd_q   <= cross3(ab_q, cd_q);
      abac_q   <= cross3(ab_q, ac_q);
      order2_q <= order1_q;
    end
    if (ld[StPart]) begin
      coll3_q <= order2_q && (abcd_q == '0) && (abac_q == '0);
    end
    if (ld[StTerm]) begin
      coll4_q <= coll3_q;
    end
    if (ld[StSum]) begin
      coll5_q <= coll4_q;
    end
    if (ld[StOut]) begin
      hit_q <= hit_d;
    end
  end

  assign dot_en.ld_part = ld[StPart];
  assign dot_en.ld_term = ld[StTerm];
  assign dot_en.ld_sum  = ld[StSum];

  sgi3d_dot_sign #(
    .ELEM_BITS(CrossBits)
  ) u_side_cd (
    .clk_i (clk_i),
    .en_i  (dot_en),
    .u_i   (acab_q),
    .v_i   (adab_q),
    .sign_o(side_cd)
  );

  sgi3d_dot_sign #(
    .ELEM_BITS(CrossBits)
  ) u_side_ab (
    .clk_i (clk_i),
    .en_i  (dot_en),
    .u_i   (cacd_q),
    .v_i   (cbcd_q),
    .sign_o(side_ab)
  );

  assign hit_d = (side_ab.neg && side_cd.neg)
              || (side_ab.neg && side_cd.zero)
              || (side_cd.neg && side_ab.zero)
              || coll5_q;

  assign in_ready_o  = ld[StDiff];
  assign out_valid_o = valid_q[StOut];
  assign hit_o       = hit_q;

  `SGI3D_ASSERT_IMP(full_when_blocked_a, !in_ready_o, (&valid_q) && !out_ready_i, "input blocked with a free stage")
  `SGI3D_ASSERT_NXT(count_held_a, !(in_valid_i && in_ready_o) && !(out_valid_o && out_ready_i), $countones(valid_q) == $past($countones(valid_q)), "transaction count changed without a transfer")
  `SGI3D_ASSERT_NXT(accept_enters_a, in_valid_i && in_ready_o, valid_q[StDiff], "accepted transaction missing from first stage")
  `SGI3D_ASSERT(sign_excl_a, !valid_q[StSum] || (!(side_ab.neg && side_ab.zero) && !(side_cd.neg && side_cd.zero)), "side value both negative and zero")

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Segment intersection 3D testbench
// Drives segment pairs AB and CD into the block and checks every hit_o
// against an exact integer model of the crossing, touching and collinear
// containment rules. Directed corner pairs come first, then random pairs:
// coplanar, touching, collinear, tiny-range and raw noise, in random
// bursts, while the output side stalls on its own changing pattern.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int COORD_BITS   = 16;
  localparam int N_RANDOM     = 850;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int U            = 256;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [127:0]          wide_t;

  // crd order: a_x a_y a_z b_x b_y b_z c_x c_y c_z d_x d_y d_z
  typedef struct {
    coord_t crd[12];
  } seg_pair_t;

  typedef enum {PAIR_NOISE, PAIR_TINY, PAIR_PLANAR, PAIR_TOUCH, PAIR_COLLINEAR} pair_kind_e;
  typedef enum {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_PERIODIC} rx_mode_e;

  class hit_scoreboard;
    bit          expected_hits[$];
    int unsigned pairs_seen;
    int unsigned hits_seen;
    int unsigned errors;

    function void cross3(input wide_t u[3], input wide_t v[3], output wide_t w[3]);
      w[0] = u[1] * v[2] - u[2] * v[1];
      w[1] = u[2] * v[0] - u[0] * v[2];
      w[2] = u[0] * v[1] - u[1] * v[0];
    endfunction

    function int dot_sign(input wide_t u[3], input wide_t v[3]);
      wide_t s;
      s = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
      return (s < 0) ? -1 : ((s == 0) ? 0 : 1);
    endfunction

    function bit is_null(input wide_t w[3]);
      return w[0] == 0 && w[1] == 0 && w[2] == 0;
    endfunction

    function bit lex_less(input wide_t p[3], input wide_t q[3]);
      if (p[0] != q[0]) return p[0] < q[0];
      if (p[1] != q[1]) return p[1] < q[1];
      return p[2] < q[2];
    endfunction

    function bit segments_meet(seg_pair_t sp);
      wide_t a[3], b[3], c[3], d[3];
      wide_t ab[3], ac[3], ad[3], cd[3], ca[3], cb[3];
      wide_t acab[3], adab[3], cacd[3], cbcd[3], abcd[3], abac[3];
      wide_t s1[3], e1[3], s2[3], e2[3];
      int side_cd, side_ab;
      for (int i = 0; i < 3; i++) begin
        a[i] = sp.crd[i];
        b[i] = sp.crd[3 + i];
        c[i] = sp.crd[6 + i];
        d[i] = sp.crd[9 + i];
      end
      for (int i = 0; i < 3; i++) begin
        ab[i] = b[i] - a[i];
        ac[i] = c[i] - a[i];
        ad[i] = d[i] - a[i];
        cd[i] = d[i] - c[i];
        ca[i] = a[i] - c[i];
        cb[i] = b[i] - c[i];
      end
      cross3(ac, ab, acab);
      cross3(ad, ab, adab);
      cross3(ca, cd, cacd);
      cross3(cb, cd, cbcd);
      cross3(ab, cd, abcd);
      side_cd = dot_sign(acab, adab);
      side_ab = dot_sign(cacd, cbcd);
      if (side_ab < 0 && side_cd < 0) return 1'b1;
      if ((side_ab < 0 && side_cd == 0) || (side_cd < 0 && side_ab == 0)) return 1'b1;
      if (!is_null(abcd)) return 1'b0;
      cross3(ab, ac, abac);
      if (!is_null(abac)) return 1'b0;
      if (lex_less(a, b)) begin
        s1 = a;
        e1 = b;
      end else begin
        s1 = b;
        e1 = a;
      end
      if (lex_less(c, d)) begin
        s2 = c;
        e2 = d;
      end else begin
        s2 = d;
        e2 = c;
      end
      return lex_less(s1, s2) && lex_less(e2, e1);
    endfunction

    function void note_pair(seg_pair_t sp);
      expected_hits.push_back(segments_meet(sp));
      pairs_seen++;
    endfunction

    function void check_hit(logic actual);
      bit want;
      if (expected_hits.size() == 0) begin
        $error("hit: expected none outstanding, actual %0b", actual);
        errors++;
        return;
      end
      want = expected_hits.pop_front();
      if (actual !== want) begin
        $error("hit: expected %0b, actual %0b", want, actual);
        errors++;
      end
      if (actual === 1'b1) hits_seen++;
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      out_ready_i = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  logic      hit_o;
  seg_pair_t drv;

  hit_scoreboard sb;
  int          burst_left = 0;
  int unsigned idle_cycles = 0;
  rx_mode_e    rx_mode = RX_ALWAYS;
  int          rx_left = 0;

  segment_intersection_3d #(
    .COORD_BITS(COORD_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .a_x_i      (drv.crd[0]),
    .a_y_i      (drv.crd[1]),
    .a_z_i      (drv.crd[2]),
    .b_x_i      (drv.crd[3]),
    .b_y_i      (drv.crd[4]),
    .b_z_i      (drv.crd[5]),
    .c_x_i      (drv.crd[6]),
    .c_y_i      (drv.crd[7]),
    .c_z_i      (drv.crd[8]),
    .d_x_i      (drv.crd[9]),
    .d_y_i      (drv.crd[10]),
    .d_z_i      (drv.crd[11]),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .hit_o      (hit_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic seg_pair_t mk_pair(int ax, int ay, int az, int bx, int by, int bz,
                                        int cx, int cy, int cz, int dx, int dy, int dz);
    seg_pair_t sp;
    sp.crd[0]  = ax;
    sp.crd[1]  = ay;
    sp.crd[2]  = az;
    sp.crd[3]  = bx;
    sp.crd[4]  = by;
    sp.crd[5]  = bz;
    sp.crd[6]  = cx;
    sp.crd[7]  = cy;
    sp.crd[8]  = cz;
    sp.crd[9]  = dx;
    sp.crd[10] = dy;
    sp.crd[11] = dz;
    return sp;
  endfunction

  function automatic int srand(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  function automatic seg_pair_t random_pair();
    seg_pair_t  sp, tmp;
    pair_kind_e kind;
    int         r, ax, px, py, pz, vx, vy, vz, wx, wy, wz, j, sc;
    int         t[4];
    r = $urandom_range(0, 99);
    if (r < 15) kind = PAIR_NOISE;
    else if (r < 30) kind = PAIR_TINY;
    else if (r < 55) kind = PAIR_PLANAR;
    else if (r < 75) kind = PAIR_TOUCH;
    else kind = PAIR_COLLINEAR;
    case (kind)
      PAIR_NOISE: begin
        for (int i = 0; i < 12; i++) sp.crd[i] = $urandom();
      end
      PAIR_TINY: begin
        for (int i = 0; i < 12; i++) sp.crd[i] = srand(4);
      end
      PAIR_PLANAR: begin
        ax = $urandom_range(0, 2);
        pz = $urandom();
        for (int i = 0; i < 12; i++) sp.crd[i] = ((i % 3) == ax) ? pz : $urandom();
      end
      PAIR_TOUCH: begin
        px = srand(1000); py = srand(1000); pz = srand(1000);
        vx = srand(50);   vy = srand(50);   vz = srand(50);
        wx = srand(200);  wy = srand(200);  wz = srand(200);
        j  = $urandom_range(0, 4);
        sp = mk_pair(px, py, pz, px + 4 * vx, py + 4 * vy, pz + 4 * vz,
                     px + j * vx, py + j * vy, pz + j * vz,
                     px + j * vx + wx, py + j * vy + wy, pz + j * vz + wz);
      end
      default: begin
        sc = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 200) : 1;
        px = srand(20000); py = srand(20000); pz = srand(20000);
        vx = srand(4) * sc; vy = srand(4) * sc; vz = srand(4) * sc;
        for (int k = 0; k < 4; k++) t[k] = srand(6);
        for (int k = 0; k < 4; k++) begin
          sp.crd[3 * k]     = px + t[k] * vx;
          sp.crd[3 * k + 1] = py + t[k] * vy;
          sp.crd[3 * k + 2] = pz + t[k] * vz;
        end
      end
    endcase
    tmp = sp;
    if ($urandom_range(0, 1)) begin
      for (int i = 0; i < 6; i++) begin
        sp.crd[i]     = tmp.crd[i + 6];
        sp.crd[i + 6] = tmp.crd[i];
      end
    end
    tmp = sp;
    if ($urandom_range(0, 1)) begin
      for (int i = 0; i < 3; i++) begin
        sp.crd[i]     = tmp.crd[i + 3];
        sp.crd[i + 3] = tmp.crd[i];
      end
    end
    if ($urandom_range(0, 1)) begin
      for (int i = 6; i < 9; i++) begin
        sp.crd[i]     = tmp.crd[i + 3];
        sp.crd[i + 3] = tmp.crd[i];
      end
    end
    return sp;
  endfunction

  task automatic send_pair(input seg_pair_t sp);
    @(negedge clk_i);
    drv        = sp;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Bursts of random length, separated by random gaps.
  task automatic feed_pair(input seg_pair_t sp);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 7))
        0, 1:    gap = 0;
        7:       gap = $urandom_range(10, 40);
        default: gap = $urandom_range(1, 5);
      endcase
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    send_pair(sp);
  endtask

  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(32, 256);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_ALWAYS:   out_ready_i = 1'b1;
      RX_MOSTLY:   out_ready_i = ($urandom_range(0, 3) != 0);
      RX_RARELY:   out_ready_i = ($urandom_range(0, 3) == 0);
      RX_PERIODIC: out_ready_i = ((rx_left % 11) < 4);
      default:     out_ready_i = 1'b1;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_pair(drv);
      if (out_valid_o && out_ready_i) sb.check_hit(hit_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("** segment_intersection_3d: FAILED **");
      $finish;
    end
  end

  initial begin
    sb = new();
    for (int i = 0; i < 12; i++) drv.crd[i] = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    feed_pair(mk_pair(0, 0, 0, 4*U, 4*U, 0, 0, 4*U, 0, 4*U, 0, 0));
    feed_pair(mk_pair(0, 0, 0, 4*U, 0, 0, 2*U, 0, 0, 2*U, 3*U, 0));
    feed_pair(mk_pair(2*U, 0, 0, 2*U, 3*U, 0, 0, 0, 0, 4*U, 0, 0));
    feed_pair(mk_pair(0, 0, 0, 4*U, 0, 0, 0, 0, 0, 0, 4*U, 0));
    feed_pair(mk_pair(0, 0, 0, U, 0, 0, 0, 2*U, 0, U, 3*U, 0));
    feed_pair(mk_pair(0, 0, 0, 4*U, 0, 0, 0, U, 0, 4*U, U, 0));
    feed_pair(mk_pair(0, 0, 0, 8*U, 0, 0, 2*U, 0, 0, 5*U, 0, 0));
    feed_pair(mk_pair(8*U, 0, 0, 0, 0, 0, 5*U, 0, 0, 2*U, 0, 0));
    feed_pair(mk_pair(0, 0, 0, 8*U, 0, 0, 0, 0, 0, 5*U, 0, 0));
    feed_pair(mk_pair(0, 0, 0, 8*U, 0, 0, 5*U, 0, 0, 12*U, 0, 0));
    feed_pair(mk_pair(2*U, 0, 0, 5*U, 0, 0, 0, 0, 0, 8*U, 0, 0));
    feed_pair(mk_pair(0, 0, 0, U, 0, 0, 2*U, 0, 0, 3*U, 0, 0));
    feed_pair(mk_pair(0, 0, -4*U, 0, 0, 4*U, 0, 0, U, 0, 0, -U));
    feed_pair(mk_pair(3, -4*U, 7, 3, 4*U, 7, 3, U, 7, 3, -U, 7));
    feed_pair(mk_pair(U, U, U, U, U, U, 0, 0, 0, 2*U, 2*U, 2*U));
    feed_pair(mk_pair(U, U, U, U, U, U, U, U, U, U, U, U));
    feed_pair(mk_pair(0, 0, 0, 4*U, 4*U, 0, 0, 4*U, U, 4*U, 0, U));
    feed_pair(mk_pair(-32768, -32768, 0, 32767, 32767, 0, -32768, 32767, 0, 32767, -32768, 0));
    feed_pair(mk_pair(32767, 32767, 32767, 32767, 32767, 32767,
                      32767, 32767, 32767, 32767, 32767, 32767));
    feed_pair(mk_pair(-32768, -32768, -32768, -32768, -32768, -32768,
                      -32768, -32768, -32768, -32768, -32768, -32768));
    feed_pair(mk_pair(-32768, -32768, -32768, 32767, 32767, 32767,
                      -100, -100, -100, 100, 100, 100));
    feed_pair(mk_pair(32767, -32768, 32767, -32768, 32767, -32768,
                      32767, 32767, -32768, -32768, -32768, 32767));

    for (int n = 0; n < N_RANDOM; n++) feed_pair(random_pair());

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.expected_hits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d segment pairs, %0d reported as hits, %0d mismatches",
             sb.pairs_seen, sb.hits_seen, sb.errors);
    $display("Covered crossings, touches, collinear containment, degenerate and extreme pairs");
    if (sb.errors == 0) begin
      $display("** segment_intersection_3d: PASSED **");
    end else begin
      $display("** segment_intersection_3d: FAILED **");
    end
    $finish;
  end

endmodule
